### sv/gap_interpolating_ema_tracker_unit_assert.svh
// Assertion macros for the gap interpolating EMA tracker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GAP_INTERPOLATING_EMA_TRACKER_UNIT_ASSERT_SVH
`define GAP_INTERPOLATING_EMA_TRACKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

### sv/gie_pkg.sv
// Shared types and constants of the gap interpolating EMA tracker.
// No dependencies; imported by every module of the block.
package gie_pkg;

	localparam int DAY_BITS     = 16;
	localparam int SAMPLE_BITS  = 16;
	// alpha is Q0.16, the averages carry 16 extra fraction bits
	localparam int FRAC_BITS    = 16;
	localparam int EMA_BITS     = SAMPLE_BITS + FRAC_BITS;
	localparam int CHG_BITS     = SAMPLE_BITS + 1;
	localparam int RATE_BITS    = 20;
	localparam int PROD_BITS    = EMA_BITS + FRAC_BITS;
	localparam int DIV_BITS     = EMA_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
	localparam int PC_BITS      = 4;

	typedef logic [DAY_BITS-1:0]           day_t;
	typedef logic [SAMPLE_BITS-1:0]        smp_t;
	typedef logic [FRAC_BITS-1:0]          alpha_t;
	typedef logic [EMA_BITS-1:0]           ema_t;
	typedef logic signed [CHG_BITS-1:0]    chg_t;
	typedef logic signed [RATE_BITS-1:0]   rate_t;
	typedef logic [PC_BITS-1:0]            pc_t;

	// jump conditions of the microcode
	typedef enum logic [2:0] {
		C_NEXT,
		C_NO_INPUT,
		C_FIRST,
		C_BAD,
		C_DIV_BUSY,
		C_MORE_DAYS,
		C_OUT_FULL,
		C_ALWAYS
	} cond_t;

	typedef enum logic {
		LANE_SHORT,
		LANE_LONG
	} lane_t;

	// one control word of the program
	typedef struct packed {
		logic  take;
		logic  setup;
		logic  first_init;
		logic  div_rate;
		logic  div_frac;
		logic  save_rate;
		logic  save_frac;
		logic  interp;
		logic  make_val;
		logic  diff;
		lane_t diff_lane;
		logic  mul;
		lane_t mul_lane;
		logic  upd;
		lane_t upd_lane;
		logic  commit;
		logic  restart;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	// datapath flags tested by the sequencer
	typedef struct packed {
		logic in_valid;
		logic first;
		logic bad;
		logic div_busy;
		logic more_days;
		logic out_full;
	} status_t;

endpackage

### sv/gap_interpolating_ema_tracker_unit.sv
// Top level of the gap interpolating EMA tracker: APB registers and block wiring.
// Depends on gie_pkg, gie_seq and gie_dp.
//
//   channel  kind          payload
//   s_axis   stream in     day_number, sample
//   m_axis   stream out    relative_day, change, week_rate, averages; tuser bad_gap
//   apb      config slave  short_alpha at 0x0, long_alpha at 0x4
//
// The first sample after reset and a sample with a zero or negative gap go straight to the commit step.
// Any other sample takes two passes of the shared one-bit-per-cycle divider, then 6 microcode
// steps per gap day around the single multiplier.
// A finished result waits in the output register; the next sample is taken meanwhile and
// its own result stalls only at the final step while m_axis_tready stays low.
// arst_n clears the step counter, the tracker state, both averages and the output valid,
// and returns the alpha registers to their defaults.
module gap_interpolating_ema_tracker_unit import gie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // day_number[15:0], sample[31:16]
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// relative_day[15:0], change[32:16], week_rate[52:33],
	// short_average[68:53], long_average[84:69], zero[87:85]
	output logic [87:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser   // bad_gap[0]
);

	localparam logic   REG_SHORT_ALPHA = 1'b0;
	localparam logic   REG_LONG_ALPHA  = 1'b1;
	localparam alpha_t SHORT_ALPHA_RST = 16'd16384;
	localparam alpha_t LONG_ALPHA_RST  = 16'd4228;
	localparam int     APB_DATA_BITS   = 32;

	alpha_t  short_alpha_q;
	alpha_t  long_alpha_q;
	logic    cfg_wr;
	logic    reg_sel;
	ucode_t  ctrl;
	status_t status;
	day_t    relative_day;
	chg_t    change;
	rate_t   week_rate;
	smp_t    short_average;
	smp_t    long_average;
	logic    bad_gap;

	// register access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];
	assign prdata  = {{(APB_DATA_BITS-FRAC_BITS){1'b0}},
	                  (reg_sel == REG_LONG_ALPHA) ? long_alpha_q : short_alpha_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_alpha_q <= SHORT_ALPHA_RST;
			long_alpha_q  <= LONG_ALPHA_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_SHORT_ALPHA: short_alpha_q <= pwdata[FRAC_BITS-1:0];
				REG_LONG_ALPHA:  long_alpha_q  <= pwdata[FRAC_BITS-1:0];
				default:         short_alpha_q <= short_alpha_q;
			endcase
		end
	end

	// sequencer
	gie_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign s_axis_tready = ctrl.take;

	// datapath
	gie_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.short_alpha   (short_alpha_q),
		.long_alpha    (long_alpha_q),
		.item_valid    (s_axis_tvalid),
		.day_number    (s_axis_tdata[15:0]),
		.sample        (s_axis_tdata[31:16]),
		.result_ready  (m_axis_tready),
		.result_valid  (m_axis_tvalid),
		.relative_day  (relative_day),
		.change        (change),
		.week_rate     (week_rate),
		.short_average (short_average),
		.long_average  (long_average),
		.bad_gap       (bad_gap),
		.status        (status)
	);

	// result packing
	assign m_axis_tdata = {3'b000, long_average, short_average, week_rate, change,
	                       relative_day};
	assign m_axis_tuser = bad_gap;

endmodule

### sv/gie_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gie_pkg.
module gie_div import gie_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [DIV_BITS-1:0] dividend,
	input  day_t                divisor,
	output logic                busy,
	output logic [DIV_BITS-1:0] quotient,
	output day_t                remainder
);

	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0]     quo_q;
	day_t                    rem_q;
	day_t                    divisor_q;
	logic [DAY_BITS:0]       shifted;
	logic [DAY_BITS:0]       trial;

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[DIV_BITS-1]};
	assign trial   = shifted - {1'b0, divisor_q};

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= DIV_CNT_BITS'(DIV_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy) begin
			if (!trial[DAY_BITS]) begin
				rem_q <= trial[DAY_BITS-1:0];
			end else begin
				rem_q <= shifted[DAY_BITS-1:0];
			end
			quo_q <= {quo_q[DIV_BITS-2:0], !trial[DAY_BITS]};
		end
	end

endmodule

### sv/gie_seq.sv
// Microcode sequencer: program ROM, step counter and jump logic.
// Depends on gie_pkg.
module gie_seq import gie_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ucode_t  ctrl
);

	// program step addresses
	localparam pc_t PC_WAIT      = 4'd0;
	localparam pc_t PC_SETUP     = 4'd1;
	localparam pc_t PC_CHECK     = 4'd2;
	localparam pc_t PC_DIV_RATE  = 4'd3;
	localparam pc_t PC_SAVE_RATE = 4'd4;
	localparam pc_t PC_DIV_FRAC  = 4'd5;
	localparam pc_t PC_SAVE_FRAC = 4'd6;
	localparam pc_t PC_INTERP    = 4'd7;
	localparam pc_t PC_VAL       = 4'd8;
	localparam pc_t PC_DIFF_S    = 4'd9;
	localparam pc_t PC_MUL_S     = 4'd10;
	localparam pc_t PC_UPD_S     = 4'd11;
	localparam pc_t PC_UPD_L     = 4'd12;
	localparam pc_t PC_COMMIT    = 4'd13;
	localparam pc_t PC_FIRST     = 4'd14;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		w = '0;
		unique case (pc)
			PC_WAIT: begin
				w.take   = 1'b1;
				w.cond   = C_NO_INPUT;
				w.target = PC_WAIT;
			end
			PC_SETUP: begin
				w.setup  = 1'b1;
				w.cond   = C_FIRST;
				w.target = PC_FIRST;
			end
			PC_CHECK: begin
				w.div_rate = 1'b1;
				w.cond     = C_BAD;
				w.target   = PC_COMMIT;
			end
			PC_DIV_RATE: begin
				w.cond   = C_DIV_BUSY;
				w.target = PC_DIV_RATE;
			end
			PC_SAVE_RATE: begin
				w.save_rate = 1'b1;
				w.div_frac  = 1'b1;
			end
			PC_DIV_FRAC: begin
				w.cond   = C_DIV_BUSY;
				w.target = PC_DIV_FRAC;
			end
			PC_SAVE_FRAC: begin
				w.save_frac = 1'b1;
			end
			PC_INTERP: begin
				w.interp = 1'b1;
			end
			PC_VAL: begin
				w.make_val = 1'b1;
			end
			PC_DIFF_S: begin
				w.diff      = 1'b1;
				w.diff_lane = LANE_SHORT;
			end
			PC_MUL_S: begin
				w.mul       = 1'b1;
				w.mul_lane  = LANE_SHORT;
				w.diff      = 1'b1;
				w.diff_lane = LANE_LONG;
			end
			PC_UPD_S: begin
				w.upd      = 1'b1;
				w.upd_lane = LANE_SHORT;
				w.mul      = 1'b1;
				w.mul_lane = LANE_LONG;
			end
			PC_UPD_L: begin
				w.upd      = 1'b1;
				w.upd_lane = LANE_LONG;
				w.cond     = C_MORE_DAYS;
				w.target   = PC_INTERP;
			end
			PC_COMMIT: begin
				w.commit  = 1'b1;
				w.restart = 1'b1;
				w.cond    = C_OUT_FULL;
				w.target  = PC_COMMIT;
			end
			PC_FIRST: begin
				w.first_init = 1'b1;
				w.cond       = C_ALWAYS;
				w.target     = PC_COMMIT;
			end
			default: begin
				w.restart = 1'b1;
			end
		endcase
		return w;
	endfunction

	pc_t  pc_q;
	pc_t  pc_d;
	logic jump;

	assign ctrl = ucode_rom(pc_q);

	// condition select
	always_comb begin
		unique case (ctrl.cond)
			C_NEXT:      jump = 1'b0;
			C_NO_INPUT:  jump = !status.in_valid;
			C_FIRST:     jump = status.first;
			C_BAD:       jump = status.bad;
			C_DIV_BUSY:  jump = status.div_busy;
			C_MORE_DAYS: jump = status.more_days;
			C_OUT_FULL:  jump = status.out_full;
			C_ALWAYS:    jump = 1'b1;
			default:     jump = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		priority if (jump) begin
			pc_d = ctrl.target;
		end else if (ctrl.restart) begin
			pc_d = PC_WAIT;
		end else begin
			pc_d = pc_q + pc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

### sv/gie_dp.sv
// Datapath: tracker state, interpolation, shared EMA multiplier, output register.
// Depends on gie_pkg, gie_div and the assertion macro header.
`include "gap_interpolating_ema_tracker_unit_assert.svh"
module gie_dp import gie_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ucode_t  ctrl,
	input  alpha_t  short_alpha,
	input  alpha_t  long_alpha,
	input  logic    item_valid,
	input  day_t    day_number,
	input  smp_t    sample,
	input  logic    result_ready,
	output logic    result_valid,
	output day_t    relative_day,
	output chg_t    change,
	output rate_t   week_rate,
	output smp_t    short_average,
	output smp_t    long_average,
	output logic    bad_gap,
	output status_t status
);

	localparam int             HALF_LSB  = 1 << (FRAC_BITS - 1);
	localparam int             EMA_WIDE  = EMA_BITS + 1;
	localparam int             SUM_BITS  = EMA_BITS + 2;
	localparam int             MAG7_BITS = SAMPLE_BITS + 3;
	localparam logic [PROD_BITS-1:0] PROD_HALF = PROD_BITS'(HALF_LSB);
	localparam logic [EMA_BITS:0]    EMA_HALF  = EMA_WIDE'(HALF_LSB);
	localparam ema_t EMA_MAX = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

	// Q16.16 average to rounded Q16.0, saturated
	function automatic smp_t ema_out(input ema_t e);
		logic [EMA_BITS:0] s;
		s = {1'b0, e} + EMA_HALF;
		if (s[EMA_BITS]) begin
			return '1;
		end
		return s[EMA_BITS-1:FRAC_BITS];
	endfunction

	// tracker state
	logic seen_first_q;
	day_t first_day_q;
	day_t prev_day_q;
	smp_t prev_smp_q;
	ema_t short_ema_q;
	ema_t long_ema_q;

	// per-item working registers
	day_t                item_day_q;
	smp_t                item_smp_q;
	day_t                gap_q;
	chg_t                change_q;
	logic                bad_q;
	rate_t               rate_q;
	logic [DIV_BITS-1:0] q0_q;
	day_t                r0_q;
	ema_t                step_q;
	day_t                rem_q;
	day_t                day_cnt_q;
	ema_t                val_q;
	ema_t                dmag_q;
	logic                dneg_q;
	logic [PROD_BITS-1:0] prod_q;
	logic                pneg_q;

	// output register
	logic  out_valid_q;
	day_t  out_rel_q;
	chg_t  out_chg_q;
	rate_t out_rate_q;
	smp_t  out_short_q;
	smp_t  out_long_q;
	logic  out_bad_q;

	logic                commit_en;
	logic [DAY_BITS:0]   gap_full;
	chg_t                chg_full;
	smp_t                chg_mag;
	logic [MAG7_BITS-1:0] mag7;
	logic [DIV_BITS-1:0] rate_dividend;
	logic [DIV_BITS-1:0] frac_dividend;
	logic                div_load;
	logic                div_busy;
	logic [DIV_BITS-1:0] div_quo;
	day_t                div_rem;
	logic [RATE_BITS-1:0] rate_mag;
	logic [DAY_BITS:0]   rem_sum;
	logic                wrap;
	day_t                rem_next;
	ema_t                step_next;
	ema_t                val_base;
	ema_t                val_next;
	ema_t                diff_ema;
	logic [EMA_BITS:0]   diff_full;
	ema_t                dmag_next;
	alpha_t              mul_alpha;
	logic [PROD_BITS-1:0] prod_next;
	logic [PROD_BITS-1:0] prod_rnd;
	ema_t                incr;
	ema_t                upd_ema;
	logic signed [SUM_BITS-1:0] ema_sum;
	ema_t                ema_next;

	// status to the sequencer
	assign status.in_valid  = item_valid;
	assign status.first     = !seen_first_q;
	assign status.bad       = bad_q;
	assign status.div_busy  = div_busy;
	assign status.more_days = (day_cnt_q != gap_q);
	assign status.out_full  = out_valid_q && !result_ready;

	assign commit_en = ctrl.commit && !status.out_full;

	// gap, change and their magnitudes
	assign gap_full = {1'b0, item_day_q} - {1'b0, prev_day_q};
	assign chg_full = chg_t'({1'b0, item_smp_q} - {1'b0, prev_smp_q});
	assign chg_mag  = change_q[CHG_BITS-1] ? smp_t'(-change_q) : change_q[SAMPLE_BITS-1:0];
	assign mag7     = {chg_mag, 3'b000} - {3'b000, chg_mag};
	assign rate_dividend = DIV_BITS'(mag7);
	assign frac_dividend = {chg_mag, {FRAC_BITS{1'b0}}};

	// shared divider: weekly rate first, then per-day interpolation increment
	assign div_load = ctrl.div_rate || ctrl.div_frac;

	gie_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (div_load),
		.dividend  (ctrl.div_frac ? frac_dividend : rate_dividend),
		.divisor   (gap_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign rate_mag = div_quo[RATE_BITS-1:0];

	// interpolation: quotient plus carried remainder each day
	assign rem_sum   = {1'b0, rem_q} + {1'b0, r0_q};
	assign wrap      = (rem_sum >= {1'b0, gap_q});
	assign rem_next  = wrap ? day_t'(rem_sum - {1'b0, gap_q}) : rem_sum[DAY_BITS-1:0];
	assign step_next = step_q + q0_q + ema_t'(wrap);
	assign val_base  = {prev_smp_q, {FRAC_BITS{1'b0}}};
	assign val_next  = change_q[CHG_BITS-1] ? val_base - step_q : val_base + step_q;

	// difference to the selected average
	assign diff_ema  = (ctrl.diff_lane == LANE_LONG) ? long_ema_q : short_ema_q;
	assign diff_full = {1'b0, val_q} - {1'b0, diff_ema};
	assign dmag_next = diff_full[EMA_BITS] ? ema_t'(-diff_full) : diff_full[EMA_BITS-1:0];

	// shared multiplier
	assign mul_alpha = (ctrl.mul_lane == LANE_LONG) ? long_alpha : short_alpha;
	assign prod_next = mul_alpha * dmag_q;

	// rounded step, half away from zero, then clamp
	assign prod_rnd = prod_q + PROD_HALF;
	assign incr     = prod_rnd[PROD_BITS-1:FRAC_BITS];
	assign upd_ema  = (ctrl.upd_lane == LANE_LONG) ? long_ema_q : short_ema_q;
	assign ema_sum  = pneg_q ? $signed({2'b00, upd_ema}) - $signed({2'b00, incr})
	                         : $signed({2'b00, upd_ema}) + $signed({2'b00, incr});

	always_comb begin
		priority if (ema_sum < 0) begin
			ema_next = '0;
		end else if (ema_sum > $signed({2'b00, EMA_MAX})) begin
			ema_next = EMA_MAX;
		end else begin
			ema_next = ema_sum[EMA_BITS-1:0];
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q <= 1'b0;
			first_day_q  <= '0;
			prev_day_q   <= '0;
			prev_smp_q   <= '0;
			short_ema_q  <= '0;
			long_ema_q   <= '0;
		end else begin
			if (ctrl.first_init) begin
				seen_first_q <= 1'b1;
				first_day_q  <= item_day_q;
				short_ema_q  <= {item_smp_q, {FRAC_BITS{1'b0}}};
				long_ema_q   <= {item_smp_q, {FRAC_BITS{1'b0}}};
			end
			if (ctrl.upd) begin
				if (ctrl.upd_lane == LANE_LONG) begin
					long_ema_q <= ema_next;
				end else begin
					short_ema_q <= ema_next;
				end
			end
			if (commit_en) begin
				prev_day_q <= item_day_q;
				prev_smp_q <= item_smp_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.take && item_valid) begin
			item_day_q <= day_number;
			item_smp_q <= sample;
		end
		if (ctrl.setup) begin
			gap_q    <= gap_full[DAY_BITS-1:0];
			bad_q    <= gap_full[DAY_BITS] || (gap_full == '0);
			change_q <= chg_full;
			rate_q   <= '0;
		end
		if (ctrl.first_init) begin
			change_q <= '0;
			bad_q    <= 1'b0;
		end
		if (ctrl.save_rate) begin
			rate_q <= change_q[CHG_BITS-1] ? rate_t'(-rate_mag) : rate_t'(rate_mag);
		end
		if (ctrl.save_frac) begin
			q0_q      <= div_quo;
			r0_q      <= div_rem;
			step_q    <= '0;
			rem_q     <= '0;
			day_cnt_q <= '0;
		end
		if (ctrl.interp) begin
			step_q    <= step_next;
			rem_q     <= rem_next;
			day_cnt_q <= day_cnt_q + day_t'(1);
		end
		if (ctrl.make_val) begin
			val_q <= val_next;
		end
		if (ctrl.diff) begin
			dmag_q <= dmag_next;
			dneg_q <= diff_full[EMA_BITS];
		end
		if (ctrl.mul) begin
			prod_q <= prod_next;
			pneg_q <= dneg_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_en) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			out_rel_q   <= item_day_q - first_day_q;
			out_chg_q   <= change_q;
			out_rate_q  <= rate_q;
			out_short_q <= ema_out(short_ema_q);
			out_long_q  <= ema_out(long_ema_q);
			out_bad_q   <= bad_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign relative_day  = out_rel_q;
	assign change        = out_chg_q;
	assign week_rate     = out_rate_q;
	assign short_average = out_short_q;
	assign long_average  = out_long_q;
	assign bad_gap       = out_bad_q;

	// averages never exceed EMA_MAX, the largest whole Q16.16 value
	`ASSERT_IMP(a_ema_in_range, clk, arst_n, 1'b1, short_ema_q <= EMA_MAX && long_ema_q <= EMA_MAX)
	// carried remainders stay below the gap while iterating
	`ASSERT_IMP(a_rem_below_gap, clk, arst_n, ctrl.interp, rem_q < gap_q && r0_q < gap_q)
	// the last interpolated day lands exactly on the new sample
	`ASSERT_IMP(a_last_day_exact, clk, arst_n, ctrl.upd && ctrl.upd_lane == LANE_LONG && day_cnt_q == gap_q, step_q == frac_dividend)
	// one item in flight: the sequencer leaves the wait step after a transfer
	`ASSERT_NXT(a_single_take, clk, arst_n, ctrl.take && item_valid, !ctrl.take)

endmodule

### tb/sv/gap_interpolating_ema_tracker_unit_tb.sv
// Self-checking testbench for the gap interpolating EMA tracker: directed samples, then
// random dated samples under several alpha settings and handshake idling patterns.
// Depends on gie_pkg and gap_interpolating_ema_tracker_unit.
module gap_interpolating_ema_tracker_unit_tb import gie_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  ADDR_SHORT_ALPHA = 3'h0;
	localparam logic [2:0]  ADDR_LONG_ALPHA  = 3'h4;
	localparam logic [31:0] SHORT_ALPHA_RST  = 32'd16384;
	localparam logic [31:0] LONG_ALPHA_RST   = 32'd4228;
	localparam longint      EMA_CEIL         = 64'h0000_0000_FFFF_0000;
	localparam int          QUIET_LIMIT      = 1_200_000;
	localparam int          HOLD_CYCLES      = 3000;
	localparam int          NUM_DIRECTED     = 15;

	typedef struct packed {
		day_t  rel_day;
		chg_t  change;
		rate_t rate;
		smp_t  short_avg;
		smp_t  long_avg;
		logic  bad;
	} tracker_result_t;

	typedef struct {
		day_t            day;
		smp_t            smp;
		bit              typed;
		tracker_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // day_number[15:0], sample[31:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// relative_day[15:0], change[32:16], week_rate[52:33],
	// short_average[68:53], long_average[84:69], zero[87:85]
	logic [87:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;   // bad_gap[0]

	gap_interpolating_ema_tracker_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// tracker state as the predictor sees it
	bit     have_first;
	day_t   ref_day;
	day_t   last_day;
	smp_t   last_smp;
	longint short_acc;
	longint long_acc;
	alpha_t short_wt;
	alpha_t long_wt;

	tracker_result_t pending_results[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_token;
	int quiet_cycles;

	// sample on each edge: first sample, zero/negative gap, day before first, rate and
	// change extremes, the largest gap, and a climb back to the top day
	stim_row_t directed_rows[NUM_DIRECTED] = '{
		'{16'd100,   16'h1234, 1'b1, '{16'd0, 17'sd0, 20'sd0, 16'h1234, 16'h1234, 1'b0}},
		'{16'd100,   16'h2000, 1'b1, '{16'd0, 17'sd3532, 20'sd0, 16'h1234, 16'h1234, 1'b1}},
		'{16'd99,    16'h1000, 1'b1, '{16'hFFFF, -17'sd4096, 20'sd0, 16'h1234, 16'h1234, 1'b1}},
		'{16'd100,   16'hFFFF, 1'b0, '0},
		'{16'd107,   16'h0000, 1'b0, '0},
		'{16'd108,   16'hFFFF, 1'b0, '0},
		'{16'd109,   16'h0000, 1'b0, '0},
		'{16'd150,   16'hFFFF, 1'b0, '0},
		'{16'd0,     16'h8000, 1'b0, '0},
		'{16'd65535, 16'hFFFF, 1'b0, '0},
		'{16'd65535, 16'h0000, 1'b0, '0},
		'{16'd65000, 16'h8001, 1'b0, '0},
		'{16'd65003, 16'h8002, 1'b0, '0},
		'{16'd65010, 16'h7FFE, 1'b0, '0},
		'{16'd65535, 16'h0001, 1'b0, '0}
	};

	// one EMA lane over a gap, fed with linearly interpolated values
	function automatic longint step_average(longint acc, longint wt, longint prev,
			longint now, longint gap);
		longint d;
		longint mag;
		longint part;
		longint val;
		longint p;
		longint i;
		d = now - prev;
		mag = (d < 0 ? -d : d) <<< 16;
		for (i = 1; i <= gap; i++) begin
			part = mag * i / gap;
			val = (prev <<< 16) + (d < 0 ? -part : part);
			p = wt * (val - acc);
			// round half away from zero
			acc += (p >= 0) ? ((p + 32768) >>> 16) : -((-p + 32768) >>> 16);
			if (acc < 0)
				acc = 0;
			if (acc > EMA_CEIL)
				acc = EMA_CEIL;
		end
		return acc;
	endfunction

	function automatic smp_t average_out(longint acc);
		longint r;
		r = (acc + 32768) >>> 16;
		return (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	// advance the tracker by one dated sample and return its result
	function automatic tracker_result_t track_sample(day_t day, smp_t smp);
		tracker_result_t r;
		longint chg;
		longint gap;
		longint rate;
		r = '0;
		if (!have_first) begin
			have_first = 1'b1;
			ref_day = day;
			short_acc = longint'(smp) <<< 16;
			long_acc = longint'(smp) <<< 16;
		end else begin
			chg = longint'(smp) - longint'(last_smp);
			gap = longint'(day) - longint'(last_day);
			r.change = chg[CHG_BITS-1:0];
			if (gap <= 0) begin
				r.bad = 1'b1;
			end else begin
				rate = chg * 7 / gap;
				r.rate = rate[RATE_BITS-1:0];
				short_acc = step_average(short_acc, longint'(short_wt), longint'(last_smp),
					longint'(smp), gap);
				long_acc = step_average(long_acc, longint'(long_wt), longint'(last_smp),
					longint'(smp), gap);
			end
		end
		last_day = day;
		last_smp = smp;
		r.rel_day = day - ref_day;
		r.short_avg = average_out(short_acc);
		r.long_avg = average_out(long_acc);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// setup and access phases, then one idle cycle before the next access
	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
		logic [31:0] got;
		apb_access(1'b0, addr, 32'd0, got);
		compare_field($sformatf("register %h", addr), want, got);
	endtask

	task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
		logic [31:0] unused;
		apb_access(1'b1, addr, value, unused);
		check_register(addr, value);
	endtask

	// offer one sample, wait for the transfer, then queue its expected result
	task automatic send_sample(input day_t day, input smp_t smp, input bit typed,
			input tracker_result_t want);
		tracker_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {smp, day};
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = track_sample(day, smp);
		pending_results = {pending_results, (typed ? want : r)};
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly forward runs of small gaps; some long gaps, jumps back and same-day repeats
	task automatic send_random(input int count);
		int k;
		int roll;
		int gap;
		int walk;
		day_t day;
		smp_t smp;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 83)
				gap = $urandom_range(8, 1);
			else if (roll < 95)
				gap = $urandom_range(60, 9);
			else if (roll < 97)
				gap = $urandom_range(400, 61);
			else
				gap = 0;
			if (gap == 0 || int'(last_day) + gap > 65535)
				day = day_t'($urandom_range(int'(last_day)));
			else
				day = day_t'(int'(last_day) + gap);
			if ($urandom_range(1)) begin
				smp = smp_t'($urandom_range(65535));
			end else begin
				walk = int'(last_smp) + $urandom_range(1024) - 512;
				smp = (walk < 0) ? 16'h0000 : (walk > 65535) ? 16'hFFFF : walk[15:0];
			end
			send_sample(day, smp, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input alpha_t s_wt,
			input alpha_t l_wt, input int count, input bit squeeze);
		wait_drained();
		set_register(ADDR_SHORT_ALPHA, {16'd0, s_wt});
		set_register(ADDR_LONG_ALPHA, {16'd0, l_wt});
		short_wt = s_wt;
		long_wt = l_wt;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (squeeze)
			hold_token++;
		send_random(count);
	endtask

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// main sequence
	initial begin
		int k;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		short_wt = SHORT_ALPHA_RST[15:0];
		long_wt = LONG_ALPHA_RST[15:0];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_register(ADDR_SHORT_ALPHA, SHORT_ALPHA_RST);
		check_register(ADDR_LONG_ALPHA, LONG_ALPHA_RST);
		for (k = 0; k < NUM_DIRECTED; k++)
			send_sample(directed_rows[k].day, directed_rows[k].smp, directed_rows[k].typed,
				directed_rows[k].want);
		run_phase(0, 0, 16'hFFFF, 16'h0001, 150, 1'b1);
		run_phase(68, 0, 16'h0001, 16'hFFFF, 150, 1'b0);
		run_phase(0, 68, alpha_t'($urandom_range(65535)), alpha_t'($urandom_range(65535)),
			150, 1'b0);
		run_phase(14, 14, 16'h0000, alpha_t'($urandom_range(65535)), 150, 1'b0);
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, one long hold-off on request, check each transfer
	initial begin
		int hold_seen;
		int hold_left;
		tracker_result_t got;
		tracker_result_t want;
		hold_seen = 0;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
				got.rel_day = m_axis_tdata[15:0];
				got.change = m_axis_tdata[32:16];
				got.rate = m_axis_tdata[52:33];
				got.short_avg = m_axis_tdata[68:53];
				got.long_avg = m_axis_tdata[84:69];
				got.bad = m_axis_tuser[0];
				if (pending_results.size() == 0) begin
					$display("%0t ns: result with none expected, got %h", $time, got);
					errors++;
				end else begin
					want = pending_results.pop_front();
					compare_field("relative_day", 32'(want.rel_day), 32'(got.rel_day));
					compare_field("change", 32'(want.change), 32'(got.change));
					compare_field("week_rate", 32'(want.rate), 32'(got.rate));
					compare_field("short_average", 32'(want.short_avg), 32'(got.short_avg));
					compare_field("long_average", 32'(want.long_avg), 32'(got.long_avg));
					compare_field("bad_gap", 32'(want.bad), 32'(got.bad));
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles without any stream transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: timeout, %0d results still expected", $time,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

### sim.f
+incdir+sv
sv/gie_pkg.sv
sv/gie_div.sv
sv/gie_seq.sv
sv/gie_dp.sv
sv/gap_interpolating_ema_tracker_unit.sv
tb/sv/gap_interpolating_ema_tracker_unit_tb.sv
